FILE: rtl/render_scale_governor_core_assert.svh
// Assertion macros for the render scale governor.
// Used by render_scale_governor_core; expects clk and rst in scope.
`ifndef RENDER_SCALE_GOVERNOR_CORE_ASSERT_SVH
`define RENDER_SCALE_GOVERNOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define RSG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("render_scale_governor_core: check failed");
`define RSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
    else $error("render_scale_governor_core: check failed");
`else
`define RSG_ASSERT(lbl, prop)
`define RSG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/rsg_pkg.sv
// Shared types and constants for the render scale governor.
// No dependencies; imported by rsg_ctrl, rsg_dp and the top level.
package rsg_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BUDGET = 2'd2;

  localparam logic        ENABLE_RST = 1'b0;
  localparam logic [9:0]  FLOOR_RST  = 10'd500;
  localparam logic [15:0] BUDGET_RST = 16'd1024;

  localparam int unsigned SCALE_MAX  = 1000;
  localparam int unsigned STEP_SMALL = 50;
  localparam int unsigned STEP_BIG   = 100;
  localparam int unsigned OVER_HOLD  = 3000;
  localparam int unsigned UNDER_HOLD = 10000;
  localparam int unsigned DOWN_GAP   = 5000;
  localparam int unsigned UP_GAP     = 20000;
  localparam int unsigned PAUSE_Q88  = 25600;

  // x / 10 == (x * RECIP10) >> 35, exact for any 32-bit x
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESET,
    OP_CLEAR,
    OP_SEED,
    OP_DIV,
    OP_AVG,
    OP_CMP,
    OP_OVER_HOLD,
    OP_DOWN,
    OP_UNDER_HOLD,
    OP_UNDER_GO,
    OP_MUL_SS,
    OP_MUL_L,
    OP_MUL_R,
    OP_UP,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic reset_path;
    logic invalid;
    logic avg_zero;
    logic over;
    logic under;
    logic hold_over;
    logic hold_under;
    logic gap_down;
    logic gap_up;
    logic pred_over;
    logic out_free;
  } status_t;

  function automatic logic [9:0] sat_scale(logic [9:0] v);
    return (v > 10'(SCALE_MAX)) ? 10'(SCALE_MAX) : v;
  endfunction

endpackage

FILE: rtl/rsg_ctrl.sv
// Sequencer for the render scale governor: walks one item through the datapath.
// Depends on rsg_pkg (op_t, status_t).
module rsg_ctrl import rsg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  status_t st,
  output op_t     op
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_AVG,
    ST_CMP,
    ST_DECIDE,
    ST_MUL_SS,
    ST_MUL_L,
    ST_MUL_R,
    ST_CHECK,
    ST_DONE
  } state_t;

  state_t state, state_next;

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          op         = OP_LOAD;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (st.reset_path) begin
          op         = OP_RESET;
          state_next = ST_DONE;
        end else if (st.invalid) begin
          op         = OP_CLEAR;
          state_next = ST_DONE;
        end else if (st.avg_zero) begin
          op         = OP_SEED;
          state_next = ST_CMP;
        end else begin
          op         = OP_DIV;
          state_next = ST_AVG;
        end
      end
      ST_AVG: begin
        op         = OP_AVG;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        op         = OP_CMP;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = ST_DONE;
        if (st.over) begin
          op = (st.hold_over || st.gap_down) ? OP_OVER_HOLD : OP_DOWN;
        end else if (st.under) begin
          if (st.hold_under || st.gap_up) begin
            op = OP_UNDER_HOLD;
          end else begin
            op         = OP_UNDER_GO;
            state_next = ST_MUL_SS;
          end
        end else begin
          op = OP_CLEAR;
        end
      end
      ST_MUL_SS: begin
        op         = OP_MUL_SS;
        state_next = ST_MUL_L;
      end
      ST_MUL_L: begin
        op         = OP_MUL_L;
        state_next = ST_MUL_R;
      end
      ST_MUL_R: begin
        op         = OP_MUL_R;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        // predicted cost over 0.9x budget: no step up
        if (!st.pred_over) begin
          op = OP_UP;
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) begin
          op         = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/rsg_dp.sv
// Datapath of the render scale governor: config registers, governor state,
// shared multiplier, timer compares and the result register. Depends on rsg_pkg.
module rsg_dp import rsg_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  op_t                      op,
  output status_t                  st,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic [31:0]              now_ms,
  input  logic [15:0]              model_ms,
  input  logic [15:0]              frame_interval_ms,
  input  logic [9:0]               ceiling_scale,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     changed,
  output logic [9:0]               scale,
  output logic [15:0]              average_ms
);

  logic                 en_r;
  logic [9:0]           floor_r;
  logic [15:0]          budget_r;

  logic [TIME_BITS-1:0] now_r;
  logic [15:0]          model_r;
  logic [15:0]          intv_r;
  logic [9:0]           ceil_r;

  logic [9:0]           cur;
  logic [15:0]          avg;
  logic [TIME_BITS-1:0] over_start;
  logic [TIME_BITS-1:0] under_start;
  logic [TIME_BITS-1:0] last_chg;

  logic                 chg_r;
  logic                 f_over, f_under, f_big;
  logic [51:0]          prod;
  logic [19:0]          pto, psc;
  logic [39:0]          lhs;

  logic                 out_v;
  logic                 out_chg;
  logic [9:0]           out_scale;
  logic [15:0]          out_avg;

  logic [9:0]           floor_sat, floor_v, to_down, to_up;
  logic [10:0]          step, up_sum;
  logic [19:0]          avg10, bud11, bud7, bud9, mix;
  logic [17:0]          avg2, bud3;
  logic [TIME_BITS-1:0] d_over, d_under, d_last;
  logic [31:0]          mul_a;
  logic [19:0]          mul_b;
  logic                 is_mul;

  assign floor_sat = sat_scale(floor_r);
  assign floor_v   = (floor_sat > ceil_r) ? ceil_r : floor_sat;

  assign avg10 = (20'(avg) << 3) + (20'(avg) << 1);
  assign bud11 = (20'(budget_r) << 3) + (20'(budget_r) << 1) + 20'(budget_r);
  assign bud7  = (20'(budget_r) << 3) - 20'(budget_r);
  assign bud9  = (20'(budget_r) << 3) + 20'(budget_r);
  assign avg2  = 18'(avg) << 1;
  assign bud3  = (18'(budget_r) << 1) + 18'(budget_r);
  assign mix   = (20'(avg) << 3) + 20'(avg) + 20'(model_r);

  assign step    = f_big ? 11'(STEP_BIG) : 11'(STEP_SMALL);
  assign to_down = (11'(cur) > (11'(floor_v) + step)) ? 10'(11'(cur) - step) : floor_v;
  assign up_sum  = 11'(cur) + 11'(STEP_SMALL);
  assign to_up   = (up_sum > 11'(ceil_r)) ? ceil_r : up_sum[9:0];

  assign d_over  = now_r - over_start;
  assign d_under = now_r - under_start;
  assign d_last  = now_r - last_chg;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    is_mul = 1'b1;
    case (op)
      OP_DIV: begin
        mul_a = RECIP10;
        mul_b = mix;
      end
      OP_UNDER_GO: begin
        mul_a = 32'(to_up);
        mul_b = 20'(to_up);
      end
      OP_MUL_SS: begin
        mul_a = 32'(cur);
        mul_b = 20'(cur);
      end
      OP_MUL_L: begin
        mul_a = 32'(pto);
        mul_b = avg10;
      end
      OP_MUL_R: begin
        mul_a = 32'(psc);
        mul_b = bud9;
      end
      default: begin
        is_mul = 1'b0;
      end
    endcase
  end

  always_comb begin
    st.reset_path = !en_r || (cur == '0) || (cur > ceil_r);
    st.invalid    = (model_r == '0) || (intv_r > 16'(PAUSE_Q88));
    st.avg_zero   = (avg == '0);
    st.over       = f_over;
    st.under      = f_under;
    st.hold_over  = (over_start == '0) || (d_over < TIME_BITS'(OVER_HOLD));
    st.hold_under = (under_start == '0) || (d_under < TIME_BITS'(UNDER_HOLD));
    st.gap_down   = (last_chg != '0) && (d_last < TIME_BITS'(DOWN_GAP));
    st.gap_up     = (last_chg != '0) && (d_last < TIME_BITS'(UP_GAP));
    st.pred_over  = (lhs > prod[39:0]);
    st.out_free   = !out_v || !result_stall;
  end

  // configuration and governor state
  always_ff @(posedge clk) begin
    if (rst) begin
      en_r        <= ENABLE_RST;
      floor_r     <= FLOOR_RST;
      budget_r    <= BUDGET_RST;
      cur         <= '0;
      avg         <= '0;
      over_start  <= '0;
      under_start <= '0;
      last_chg    <= '0;
      out_v       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: en_r     <= cfg_data[0];
          CFG_FLOOR:  floor_r  <= cfg_data[9:0];
          CFG_BUDGET: budget_r <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (op == OP_EMIT) begin
        out_v <= 1'b1;
      end else if (!result_stall) begin
        out_v <= 1'b0;
      end

      case (op)
        OP_RESET: begin
          cur         <= ceil_r;
          over_start  <= '0;
          under_start <= '0;
          if (!en_r) begin
            avg <= '0;
          end
        end
        OP_CLEAR: begin
          over_start  <= '0;
          under_start <= '0;
        end
        OP_SEED: avg <= model_r;
        OP_AVG:  avg <= prod[RECIP_SHIFT +: 16];
        OP_OVER_HOLD: begin
          under_start <= '0;
          if (over_start == '0) begin
            over_start <= now_r;
          end
        end
        OP_UNDER_HOLD: begin
          over_start <= '0;
          if (under_start == '0) begin
            under_start <= now_r;
          end
        end
        OP_UNDER_GO: over_start <= '0;
        OP_DOWN, OP_UP: begin
          cur         <= (op == OP_DOWN) ? to_down : to_up;
          last_chg    <= now_r;
          over_start  <= '0;
          under_start <= '0;
          avg         <= '0;
        end
        default: ;
      endcase
    end
  end

  // item payload, working registers and result register
  always_ff @(posedge clk) begin
    if (is_mul) begin
      prod <= 52'(mul_a) * 52'(mul_b);
    end
    case (op)
      OP_LOAD: begin
        now_r   <= TIME_BITS'(now_ms);
        model_r <= model_ms;
        intv_r  <= frame_interval_ms;
        ceil_r  <= sat_scale(ceiling_scale);
        chg_r   <= 1'b0;
      end
      OP_RESET: chg_r <= (cur != ceil_r) && (cur != '0) && en_r;
      OP_CMP: begin
        f_over  <= (avg10 > bud11) && (cur > floor_v);
        f_under <= (avg10 < bud7) && (cur < ceil_r);
        f_big   <= (avg2 > bud3);
      end
      OP_MUL_SS: pto <= prod[19:0];
      OP_MUL_L:  psc <= prod[19:0];
      OP_MUL_R:  lhs <= prod[39:0];
      OP_DOWN, OP_UP: chg_r <= 1'b1;
      OP_EMIT: begin
        out_chg   <= chg_r;
        out_scale <= cur;
        out_avg   <= avg;
      end
      default: ;
    endcase
  end

  assign result_valid = out_v;
  assign changed      = out_chg;
  assign scale        = out_scale;
  assign average_ms   = out_avg;

endmodule

FILE: rtl/render_scale_governor_core.sv
// Render scale governor top level: sequencer plus datapath.
// Depends on rsg_pkg, rsg_ctrl, rsg_dp and render_scale_governor_core_assert.svh.
//
// One item per frame in, one result out. After an item is accepted the block
// takes its shortest path to a loaded result on the disabled, first-item, pause
// and invalid-sample paths, a longer one when the moving average is updated and
// the scale holds or steps down, and its longest when a step up is tested, which
// runs four products in turn through the one shared 32x20 multiplier. Stall stays
// high from acceptance until the result is loaded into the output register;
// a result waiting there does not block the next item, but the item after it
// waits for that register to empty. Configuration writes take effect at once
// and are meant for idle periods only.
`include "render_scale_governor_core_assert.svh"

module render_scale_governor_core import rsg_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [31:0]              now_ms,
  input  logic [15:0]              model_ms,
  input  logic [15:0]              frame_interval_ms,
  input  logic [9:0]               ceiling_scale,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     changed,
  output logic [9:0]               scale,
  output logic [15:0]              average_ms
);

  op_t     op;
  status_t st;

  rsg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .op         (op)
  );

  rsg_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .op                (op),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .now_ms            (now_ms),
    .model_ms          (model_ms),
    .frame_interval_ms (frame_interval_ms),
    .ceiling_scale     (ceiling_scale),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .changed           (changed),
    .scale             (scale),
    .average_ms        (average_ms)
  );

  `RSG_ASSERT(a_scale_range, result_valid |-> (scale <= 10'(SCALE_MAX)))
  `RSG_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
  `RSG_ASSERT(a_no_overwrite, (op == OP_EMIT) |-> !(result_valid && result_stall))
  `RSG_ASSERT(a_valid_from_emit, $rose(result_valid) |-> $past(op == OP_EMIT))

endmodule
